### rtl/assert_macros.svh
// Assertion macros shared by the sparse weight update decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWUD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SWUD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swud_pkg.sv
// Shared types and constants of the sparse weight update decoder.
package swud_pkg;

  localparam logic [7:0] BYTE_OPEN      = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
  localparam logic [7:0] BYTE_ALT_CLOSE = 8'h28;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_SHIFT = 2'd2;

  localparam logic [15:0] RESET_SECTION_SIZE = 16'd804;
  localparam logic [3:0]  RESET_HEADER_BITS  = 4'd11;
  localparam logic [3:0]  RESET_LENGTH_SHIFT = 4'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [15:0] section_size;
    logic [3:0]  header_bits;
    logic [3:0]  length_shift;
  } swud_cfg_t;

  // One decoded write, waiting for its address to be formed.
  typedef struct packed {
    logic [6:0]  section;
    logic [15:0] index;
    logic [15:0] value;
  } swud_cmd_t;

endpackage

### rtl/sparse_weight_update_decoder.sv
// Top level of the sparse weight update decoder: configuration and wiring.
//
// Received bytes enter on rx_byte with in_valid; a byte is taken at a rising
// edge where in_valid is high and in_stall is low. Weight writes leave on
// weight_address and weight_value with out_valid, and are taken at an edge
// where out_valid is high and out_stall is low. One byte is taken every cycle
// while the internal queue has room; one write word leaves per cycle at most.
// Once the low byte of a point is taken, the parser adds the run offset to
// the block index and files the write into a four-entry queue; when the
// output is free, the address stage forms section * section_size + index
// (one 7 by 16 bit multiply and an add) and loads the output register.
// When the receiver stalls, the output holds its word, the queue fills, and
// in_stall rises only once all four queue entries are taken, so bytes keep
// flowing for a while. Reset (synchronous, active high) empties the queue,
// drops the output word, leaves the parser outside any frame and restores
// section_size = 804, header_bits = 11 and length_shift = 4.
// Configuration is written through cfg_write, cfg_index and cfg_data, and
// must only be changed while no write is still in flight.

module sparse_weight_update_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [swud_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [swud_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                          rx_byte,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic [15:0]                         weight_address,
  output logic signed [15:0]                  weight_value,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import swud_pkg::*;

  swud_cfg_t cfg;
  swud_cmd_t push_cmd;
  swud_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  // Configuration registers; an index beyond the list writes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.section_size <= RESET_SECTION_SIZE;
      cfg.header_bits  <= RESET_HEADER_BITS;
      cfg.length_shift <= RESET_LENGTH_SHIFT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SECTION_SIZE: cfg.section_size <= cfg_data;
        CFG_HEADER_BITS:  cfg.header_bits  <= cfg_data[3:0];
        CFG_LENGTH_SHIFT: cfg.length_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front: frame and header parsing, one write command per completed point.
  swud_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // The queue lets the parser run on while the receiver holds the output.
  swud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  // Back: address arithmetic and the registered output word.
  swud_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_cmd          (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .weight_address (weight_address),
    .weight_value   (weight_value)
  );

endmodule

### rtl/swud_queue.sv
// Short register queue between the byte parser and the address stage.
`include "assert_macros.svh"

module swud_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  swud_pkg::swud_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output swud_pkg::swud_cmd_t pop_cmd
);
  import swud_pkg::*;

  swud_cmd_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `SWUD_ASSERT_NXT(a_fill_grows, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not grow on push")
  `SWUD_ASSERT_IMP(a_no_overrun, clk, rst, full, !push, "push into a full queue")

endmodule

### rtl/swud_front.sv
// Byte parser: frames, headers, block words and points, one byte a cycle while the queue has room.
`include "assert_macros.svh"

module swud_front (
  input  logic                clk,
  input  logic                rst,
  input  swud_pkg::swud_cfg_t cfg,
  input  logic [7:0]          rx_byte,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                q_full,
  output logic                push,
  output swud_pkg::swud_cmd_t push_cmd
);
  import swud_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BLOCK_LO,
    PH_POINT_HI,
    PH_POINT_LO
  } phase_t;

  phase_t      phase;
  logic        in_frame;
  logic [7:0]  held_byte;
  logic [6:0]  section_number;
  logic [14:0] block_index;
  logic [14:0] run_length;
  logic [14:0] run_offset;

  logic        accept;
  logic        is_open;
  logic        is_close;
  logic        is_data;
  logic        run_last;
  logic [15:0] word;
  logic [3:0]  hb_eff;
  logic [14:0] len_mask;
  logic [14:0] new_index;
  logic [14:0] new_length;

  always_comb begin
    accept     = in_valid && !in_stall;
    is_open    = (rx_byte == BYTE_OPEN);
    is_close   = (rx_byte == BYTE_CLOSE) || (rx_byte == BYTE_ALT_CLOSE);
    is_data    = in_frame && !is_open && !is_close;
    word       = {held_byte, rx_byte};
    hb_eff     = (cfg.header_bits == 4'd0) ? 4'd1 : cfg.header_bits;
    len_mask   = 15'h7FFF >> (hb_eff - 4'd1);
    new_index  = word[14:0] >> cfg.length_shift;
    new_length = word[14:0] & len_mask;
    run_last   = (run_length == '0) || (run_offset == 15'(run_length - 15'd1));
  end

  assign in_stall        = q_full;
  assign push            = accept && is_data && (phase == PH_POINT_LO);
  assign push_cmd.section = section_number;
  assign push_cmd.index  = {1'b0, block_index} + {1'b0, run_offset};
  assign push_cmd.value  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      phase    <= PH_HEADER;
    end else if (accept) begin
      if (is_open) begin
        in_frame       <= 1'b1;
        phase          <= PH_HEADER;
        held_byte      <= '0;
        section_number <= '0;
        block_index    <= '0;
        run_length     <= '0;
        run_offset     <= '0;
      end else if (is_close) begin
        in_frame <= 1'b0;
      end else if (in_frame) begin
        unique case (phase)
          PH_HEADER: begin
            if (rx_byte[7]) begin
              held_byte <= rx_byte;
              phase     <= PH_BLOCK_LO;
            end else begin
              section_number <= rx_byte[6:0];
            end
          end
          PH_BLOCK_LO: begin
            block_index <= new_index;
            run_length  <= new_length;
            run_offset  <= '0;
            phase       <= (new_length == '0) ? PH_HEADER : PH_POINT_HI;
          end
          PH_POINT_HI: begin
            held_byte <= rx_byte;
            phase     <= PH_POINT_LO;
          end
          PH_POINT_LO: begin
            if (run_last) begin
              run_offset <= '0;
              run_length <= '0;
              phase      <= PH_HEADER;
            end else begin
              run_offset <= run_offset + 15'd1;
              phase      <= PH_POINT_HI;
            end
          end
          default: phase <= PH_HEADER;
        endcase
      end
    end
  end

  `SWUD_ASSERT_NXT(a_run_ends, clk, rst, push && run_last, phase == PH_HEADER && run_offset == '0, "run did not return to header mode")

endmodule

### rtl/swud_back.sv
// Address stage and output register: section base plus point index (block index and offset).
`include "assert_macros.svh"

module swud_back (
  input  logic                clk,
  input  logic                rst,
  input  swud_pkg::swud_cfg_t cfg,
  input  logic                q_valid,
  input  swud_pkg::swud_cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         weight_address,
  output logic signed [15:0]  weight_value
);
  import swud_pkg::*;

  logic        load;
  logic [22:0] product;
  logic [15:0] addr;

  always_comb begin
    load    = !out_valid || !out_stall;
    product = q_cmd.section * cfg.section_size;
    addr    = product[15:0] + q_cmd.index;
  end

  assign pop = q_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      weight_address <= addr;
      weight_value   <= $signed(q_cmd.value);
    end
  end

  `SWUD_ASSERT_NXT(a_pop_shows, clk, rst, pop, out_valid, "popped word did not reach the output")

endmodule
